// ===== sv/wdcs_pkg.sv =====
// wdcs_pkg: widths, codes and residue helpers of the weighted digit check sum
// used by weighted_digit_check_sum_core; depends on nothing else
`default_nettype none

package wdcs_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned ValueW  = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned MethodW = 3;
  localparam int unsigned CountW  = 4;
  localparam int unsigned SumW    = 8;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  // method register codes
  localparam logic [MethodW-1:0] METHOD_7_MOD_11 = 3'd1;
  localparam logic [MethodW-1:0] METHOD_9_MOD_11 = 3'd2;
  localparam logic [MethodW-1:0] METHOD_7_MOD_26 = 3'd3;
  localparam logic [MethodW-1:0] METHOD_7_MOD_10 = 3'd4;
  localparam logic [MethodW-1:0] METHOD_9_MOD_10 = 3'd5;
  localparam logic [MethodW-1:0] METHOD_RESET    = METHOD_7_MOD_11;

  // register index
  localparam logic [AddrW-3:0] REG_METHOD = 1'b0;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [StatusW-1:0] STATUS_BAD_CHAR = 2'd2;

  localparam logic [CharW-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CharW-1:0] CHAR_NINE = 8'h39;

  localparam logic [ValueW-1:0] MOD11_FOLD = 5'd10;

  typedef enum logic [1:0] {
    MOD_11,
    MOD_26,
    MOD_10
  } modulus_e;

  function automatic logic method_valid(input logic [MethodW-1:0] m);
    return (m == METHOD_7_MOD_11) || (m == METHOD_9_MOD_11) || (m == METHOD_7_MOD_26) ||
           (m == METHOD_7_MOD_10) || (m == METHOD_9_MOD_10);
  endfunction

  function automatic logic method_base_nine(input logic [MethodW-1:0] m);
    return (m == METHOD_9_MOD_11) || (m == METHOD_9_MOD_10);
  endfunction

  function automatic modulus_e method_modulus(input logic [MethodW-1:0] m);
    modulus_e res;
    case (m)
      METHOD_7_MOD_11, METHOD_9_MOD_11: res = MOD_11;
      METHOD_7_MOD_26:                  res = MOD_26;
      default:                          res = MOD_10;
    endcase
    return res;
  endfunction

  function automatic logic [ValueW-1:0] modulus_max(input modulus_e md);
    logic [ValueW-1:0] res;
    case (md)
      MOD_11:  res = 5'd10;
      MOD_26:  res = 5'd25;
      MOD_10:  res = 5'd9;
      default: res = 5'd9;
    endcase
    return res;
  endfunction

  // reciprocal multiply gives the quotient, exact for every sum the update can make
  function automatic logic [ValueW-1:0] mod_reduce(input logic [SumW-1:0] sum,
                                                   input modulus_e md);
    logic [2*SumW-1:0] prod;
    logic [ValueW-1:0] quot;
    logic [SumW-1:0]   rem;
    prod = '0;
    quot = '0;
    rem  = '0;
    case (md)
      MOD_11: begin
        prod = {8'd0, sum} * 16'd187;
        quot = prod[15:11];
        rem  = sum - ({3'd0, quot} * 8'd11);
      end
      MOD_26: begin
        prod = {8'd0, sum} * 16'd79;
        quot = prod[15:11];
        rem  = sum - ({3'd0, quot} * 8'd26);
      end
      default: begin
        prod = {8'd0, sum} * 16'd205;
        quot = prod[15:11];
        rem  = sum - ({3'd0, quot} * 8'd10);
      end
    endcase
    return rem[ValueW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/weighted_digit_check_sum_core.sv =====
// weighted_digit_check_sum_core: weighted modulus check digit over a stream of
// ascii characters; depends on wdcs_pkg
//
// usage
//   input channel: digit_char_i and last_digit_i under in_valid_i / in_ready_o,
//   most significant character first, last_digit_i marks the final one.
//   output channel: check_value_o and status_o under out_valid_o / out_ready_i,
//   one request per number, produced by its marked character only.
//   apb port: one register, method, at byte address 0; writes of codes other
//   than 1..5 are dropped, a good write clears the number in progress.
// timing
//   a character sits in the input register while its residue update is worked
//   out; the result register takes the result when the marked character leaves
//   it. one character per cycle is sustained while no marked character is held
//   up, the residue update being the only loop (multiply by the base, add,
//   constant-modulus reduce, all combinational).
// reset
//   method returns to 7 mod 11, residue, count and error flag clear, both
//   pipeline registers empty.
// stall
//   while a result waits, characters that end no number still flow on; a
//   second marked character waits in the input register and then the input
//   channel drops ready.
`default_nettype none

module weighted_digit_check_sum_core
  import wdcs_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input characters
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [CharW-1:0]     digit_char_i,
  input  wire logic                 last_digit_i,
  // results
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [ValueW-1:0]         check_value_o,
  output logic [StatusW-1:0]        status_o,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrW-1:0]     paddr,
  input  wire logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]          prdata,
  output logic                      pready
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_DIGITS);

  logic [MethodW-1:0] method_q;
  logic [ValueW-1:0]  residue_q, residue_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               bad_q, bad_d;

  logic               s1_valid_q;
  logic [CharW-1:0]   s1_char_q;
  logic               s1_last_q;

  logic               out_valid_q;
  logic [ValueW-1:0]  value_q, value_d;
  logic [StatusW-1:0] status_q, status_d;

  logic               cfg_wr, method_wr;
  logic [MethodW-1:0] wr_method;
  logic               advance;
  modulus_e           modulus;
  logic               is_digit;
  logic [CharW-1:0]   char_off;
  logic [SumW-1:0]    res_ext, scaled, sum;
  logic [ValueW-1:0]  residue_red;

  // apb
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign wr_method = pwdata[MethodW-1:0];
  assign method_wr = cfg_wr && (paddr[AddrW-1:2] == REG_METHOD) && method_valid(wr_method);
  assign prdata    = (paddr[AddrW-1:2] == REG_METHOD) ?
                     {{(DataW-MethodW){1'b0}}, method_q} : '0;

  // handshakes: a non-final character needs no room at the output
  assign advance     = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;

  // residue update
  assign modulus  = method_modulus(method_q);
  assign is_digit = (s1_char_q >= CHAR_ZERO) && (s1_char_q <= CHAR_NINE);
  assign char_off = s1_char_q - CHAR_ZERO;
  assign res_ext  = {3'd0, residue_q};
  assign scaled   = method_base_nine(method_q) ? ((res_ext << 3) + res_ext)
                                               : ((res_ext << 3) - res_ext);
  assign sum      = scaled + {4'd0, char_off[3:0]};
  assign residue_red = mod_reduce(sum, modulus);

  always_comb begin
    residue_d = is_digit ? residue_red : residue_q;
    count_d   = (count_q <= MaxCount) ? count_q + 4'd1 : count_q;
    bad_d     = bad_q || !is_digit;
    if (count_d > MaxCount) begin
      status_d = STATUS_TOO_LONG;
      value_d  = '0;
    end else if (bad_d) begin
      status_d = STATUS_BAD_CHAR;
      value_d  = '0;
    end else begin
      status_d = STATUS_OK;
      value_d  = ((modulus == MOD_11) && (residue_d == MOD11_FOLD)) ? '0 : residue_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q  <= METHOD_RESET;
      residue_q <= '0;
      count_q   <= '0;
      bad_q     <= 1'b0;
    end else if (method_wr) begin
      method_q  <= wr_method;
      residue_q <= '0;
      count_q   <= '0;
      bad_q     <= 1'b0;
    end else if (advance) begin
      if (s1_last_q) begin
        residue_q <= '0;
        count_q   <= '0;
        bad_q     <= 1'b0;
      end else begin
        residue_q <= residue_d;
        count_q   <= count_d;
        bad_q     <= bad_d;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_char_q <= digit_char_i;
      s1_last_q <= last_digit_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign check_value_o = value_q;
  assign status_o      = status_q;

  // checks
  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    residue_q <= modulus_max(modulus))
    else $error("running residue out of range for method");

  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount + 4'd1)
    else $error("character count past saturation");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |-> check_value_o == '0)
    else $error("check value not zero on error status");

  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_OK) |-> check_value_o <= 5'd25)
    else $error("check value beyond largest modulus");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s1_last_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked final character");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_last_q |=> count_q == '0 && !bad_q)
    else $error("number state not cleared after result");

endmodule

`default_nettype wire

// ===== test/weighted_digit_check_sum_core_tb.sv =====
// weighted_digit_check_sum_core_tb: self-checking bench for the weighted check digit core,
// with a residue predictor, random idling on both channels and method register traffic
// depends on wdcs_pkg and weighted_digit_check_sum_core
module weighted_digit_check_sum_core_tb;
  import wdcs_pkg::*;

  localparam int unsigned MAX_DIGITS  = 10;
  localparam int unsigned PIPE_DRAIN  = 4;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 120;

  localparam logic [AddrW-1:0] METHOD_ADDR = {REG_METHOD, 2'b00};
  localparam logic [AddrW-1:0] SPARE_ADDR  = {~REG_METHOD, 2'b00};

  localparam logic [MethodW-1:0] METHOD_NONE   = 3'd0;
  localparam logic [MethodW-1:0] METHOD_SPARE6 = 3'd6;
  localparam logic [MethodW-1:0] METHOD_SPARE7 = 3'd7;
  localparam logic [MethodW-1:0] BAD_METHODS [3] = '{METHOD_NONE, METHOD_SPARE6, METHOD_SPARE7};
  localparam logic [MethodW-1:0] PHASE_METHODS [5] = '{METHOD_7_MOD_11, METHOD_9_MOD_10,
                                                       METHOD_7_MOD_26, METHOD_9_MOD_11,
                                                       METHOD_7_MOD_10};
  localparam logic [CharW-1:0] CHAR_LOW  = 8'h00;
  localparam logic [CharW-1:0] CHAR_HIGH = 8'hFF;

  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [StatusW-1:0] status;
  } check_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [CharW-1:0]     digit_char_i = '0;
  logic                 last_digit_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ValueW-1:0]    check_value_o;
  logic [StatusW-1:0]   status_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrW-1:0]     paddr = '0;
  logic [DataW-1:0]     pwdata = '0;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  // predictor state
  logic [MethodW-1:0]   cfg_method = METHOD_RESET;
  int unsigned          num_residue = 0;
  int unsigned          num_length = 0;
  bit                   num_bad_char = 1'b0;

  check_result_t        pending_checks[$];
  int unsigned          fail_count = 0;
  int unsigned          sent_chars = 0;
  int unsigned          idle_cycles = 0;
  bit                   steady = 1'b0;

  weighted_digit_check_sum_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .digit_char_i (digit_char_i),
    .last_digit_i (last_digit_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .check_value_o(check_value_o),
    .status_o     (status_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_number();
    num_residue  = 0;
    num_length   = 0;
    num_bad_char = 1'b0;
  endfunction

  // horner step on one character; returns 1 when the character closes a number
  function automatic bit predict_char(input logic [CharW-1:0] ch, input logic last,
                                      output check_result_t res);
    int unsigned base;
    int unsigned modulus;
    base = (cfg_method == METHOD_9_MOD_11 || cfg_method == METHOD_9_MOD_10) ? 9 : 7;
    if (cfg_method == METHOD_7_MOD_11 || cfg_method == METHOD_9_MOD_11) begin
      modulus = 11;
    end else if (cfg_method == METHOD_7_MOD_26) begin
      modulus = 26;
    end else begin
      modulus = 10;
    end
    res = '0;
    if (num_length <= MAX_DIGITS) num_length++;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      num_residue = (num_residue * base + (int'(ch) - int'(CHAR_ZERO))) % modulus;
    end else begin
      num_bad_char = 1'b1;
    end
    if (!last) return 1'b0;
    if (num_length > MAX_DIGITS) begin
      res.status = STATUS_TOO_LONG;
    end else if (num_bad_char) begin
      res.status = STATUS_BAD_CHAR;
    end else begin
      res.status = STATUS_OK;
      res.value  = ValueW'(num_residue);
      // mod 11 folds a residue of ten onto zero
      if (modulus == 11 && res.value == MOD11_FOLD) res.value = '0;
    end
    clear_number();
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_char(input logic [CharW-1:0] ch, input logic last);
    int unsigned gap;
    check_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    digit_char_i <= ch;
    last_digit_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_chars++;
    if (predict_char(ch, last, res)) pending_checks.push_back(res);
  endtask

  task automatic send_number(input string digits);
    for (int i = 0; i < digits.len(); i++) begin
      send_char(digits[i], i == digits.len() - 1);
    end
  endtask

  // input idle, every result back, pipeline empty
  task automatic settle_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_checks.size() != 0) @(posedge clk_i);
    repeat (PIPE_DRAIN) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [DataW-1:0] wdata, output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_method_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    logic [DataW-1:0] unused;
    apb_access(1'b1, addr, data, unused);
    if (addr == METHOD_ADDR && data[MethodW-1:0] >= METHOD_7_MOD_11 &&
        data[MethodW-1:0] <= METHOD_9_MOD_10) begin
      cfg_method = data[MethodW-1:0];
      clear_number();
    end
  endtask

  task automatic check_method_reg();
    logic [DataW-1:0] rdata;
    apb_access(1'b0, METHOD_ADDR, '0, rdata);
    if (rdata !== DataW'(cfg_method)) begin
      $error("method: expected %0d, actual %0d", cfg_method, rdata);
      fail_count++;
    end
  endtask

  task automatic send_random_number();
    int unsigned kind;
    int unsigned len;
    int unsigned noise;
    logic [CharW-1:0] ch;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      len   = $urandom_range(1, MAX_DIGITS);
      noise = 0;
    end else if (kind < 85) begin
      len   = $urandom_range(1, MAX_DIGITS);
      noise = 40;
    end else begin
      len   = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 6);
      noise = 20;
    end
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < noise) ch = CharW'($urandom_range(0, 255));
      else ch = CHAR_ZERO + CharW'($urandom_range(0, 9));
      send_char(ch, i == len - 1);
    end
  endtask

  task automatic test_number_edges();
    check_method_reg();
    send_number("0");
    send_number("9999999999");
    send_number("13");
    send_char(CHAR_LOW, 1'b1);
    // eleven characters, one of them not a digit: length wins
    for (int i = 0; i < MAX_DIGITS + 1; i++) begin
      send_char((i == 5) ? CHAR_HIGH : CHAR_NINE, i == MAX_DIGITS);
    end
    settle_block();
  endtask

  task automatic test_method_register();
    foreach (BAD_METHODS[i]) write_method_reg(METHOD_ADDR, DataW'(BAD_METHODS[i]));
    write_method_reg(SPARE_ADDR, DataW'(METHOD_7_MOD_26));
    check_method_reg();
    // upper data bits do not matter
    write_method_reg(METHOD_ADDR, {{(DataW-MethodW){1'b1}}, METHOD_9_MOD_10});
    check_method_reg();
    foreach (PHASE_METHODS[i]) begin
      write_method_reg(METHOD_ADDR, DataW'(PHASE_METHODS[i]));
      check_method_reg();
      send_number("87");
      send_number("/:");
      settle_block();
    end
    // a good write drops the number in progress
    send_char(CHAR_ZERO + 8'd4, 1'b0);
    send_char(CHAR_ZERO + 8'd8, 1'b0);
    settle_block();
    write_method_reg(METHOD_ADDR, DataW'(METHOD_7_MOD_26));
    send_number("2");
    settle_block();
  endtask

  task automatic test_random_numbers();
    int unsigned start;
    foreach (PHASE_METHODS[ph]) begin
      steady = (ph == 2);
      write_method_reg(METHOD_ADDR,
                       {(DataW-MethodW)'($urandom()), BAD_METHODS[$urandom_range(0, 2)]});
      write_method_reg(METHOD_ADDR, {(DataW-MethodW)'($urandom()), PHASE_METHODS[ph]});
      check_method_reg();
      start = sent_chars;
      while (sent_chars - start < PHASE_ITEMS) send_random_number();
      settle_block();
    end
    steady = 1'b0;
  endtask

  // result side: random back-pressure and in-order compare
  always @(posedge clk_i) begin : result_check
    int unsigned hold_left;
    check_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_checks.size() == 0) begin
        $error("unexpected result: check_value %0d status %0d", check_value_o, status_o);
        fail_count++;
      end else begin
        want = pending_checks.pop_front();
        if (check_value_o !== want.value) begin
          $error("check_value: expected %0d, actual %0d", want.value, check_value_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      hold_left = pick_gap();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_number_edges();
    test_method_register();
    test_random_numbers();
    settle_block();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/wdcs_pkg.sv
sv/weighted_digit_check_sum_core.sv
test/weighted_digit_check_sum_core_tb.sv
